// ----- rtl/nba_pkg.sv -----
// Shared constants and control types for the nearest bone search block.
// Used by nba_ctrl, nba_dp and nearest_bone_assign.
package nba_pkg;
	localparam int COORD_BITS = 20;
	localparam int MAX_BONES  = 64;
	localparam int IDX_BITS   = 6;
	localparam int CNT_BITS   = 7;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * DIFF_BITS - 1;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int ROOT_BITS  = SUM_BITS / 2;
	localparam int REM_BITS   = ROOT_BITS + 2;
	localparam int STEP_BITS  = 5;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                capture;
		logic                load;
		logic                rd;
		logic [IDX_BITS-1:0] addr;
		logic                sq;
		logic                sum;
		logic                sqrt_step;
		logic                cmp;
		logic                first;
		logic                out_load;
		logic                found;
	} dp_cmd_t;
endpackage

// ----- rtl/nearest_bone_assign.sv -----
// Top level of the nearest bone search block: nba_ctrl plus nba_dp.
// Depends on nba_pkg.
//
// Channel   Signals                                          Direction
// cfg       cfg_we, cfg_wdata (bone_count)                   in
// input     in_valid/in_ready, command .. last_vertex        in
// output    out_valid/out_ready, bone_index, assigned, last_out  out
//
// A load word is written to the table in idle. For a query, each of the n bones in use
// (n is the bone count, at most 64) needs a table read, squaring, a sum, 21 square root
// steps and a compare; then the result register is loaded once it is free, and the next
// word can be taken in idle after that.
// Reset clears control state and the bone count; the table is not cleared.
// A finished result waits in the output register while the next word is taken.
module nearest_bone_assign (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic        [nba_pkg::CNT_BITS-1:0]   cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic        [nba_pkg::IDX_BITS-1:0]   bone_slot,
	input  logic signed [nba_pkg::COORD_BITS-1:0] coord_x,
	input  logic signed [nba_pkg::COORD_BITS-1:0] coord_y,
	input  logic signed [nba_pkg::COORD_BITS-1:0] coord_z,
	input  logic                                already_attached,
	input  logic                                last_vertex,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [nba_pkg::IDX_BITS-1:0]   bone_index,
	output logic                                assigned,
	output logic                                last_out
);
	nba_pkg::dp_cmd_t cmd;

	nba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.already_attached(already_attached), .out_valid(out_valid),
		.out_ready(out_ready), .cmd(cmd)
	);

	nba_dp u_dp (
		.clk(clk), .cmd(cmd), .bone_slot(bone_slot), .coord_x(coord_x),
		.coord_y(coord_y), .coord_z(coord_z), .last_vertex(last_vertex),
		.bone_index(bone_index), .assigned(assigned), .last_out(last_out)
	);
endmodule

// ----- rtl/nba_dp.sv -----
// Datapath: bone table memory, squared distance, iterative square root,
// running minimum and output payload registers. Depends on nba_pkg.
module nba_dp (
	input  logic                                clk,
	input  nba_pkg::dp_cmd_t                    cmd,
	input  logic        [nba_pkg::IDX_BITS-1:0]   bone_slot,
	input  logic signed [nba_pkg::COORD_BITS-1:0] coord_x,
	input  logic signed [nba_pkg::COORD_BITS-1:0] coord_y,
	input  logic signed [nba_pkg::COORD_BITS-1:0] coord_z,
	input  logic                                last_vertex,
	output logic        [nba_pkg::IDX_BITS-1:0]   bone_index,
	output logic                                assigned,
	output logic                                last_out
);
	localparam int CB = nba_pkg::COORD_BITS;
	localparam int DB = nba_pkg::DIFF_BITS;
	localparam int QB = nba_pkg::SQ_BITS;
	localparam int SB = nba_pkg::SUM_BITS;
	localparam int RB = nba_pkg::ROOT_BITS;
	localparam int MB = nba_pkg::REM_BITS;

	logic [3*CB-1:0] mem_q [nba_pkg::MAX_BONES];
	logic [3*CB-1:0] rd_q;
	logic signed [CB-1:0] vx_q, vy_q, vz_q;
	logic last_q;
	logic [QB-1:0] sqx_q, sqy_q, sqz_q;
	logic [SB-1:0] val_q;
	logic [MB-1:0] rem_q;
	logic [RB-1:0] root_q, best_d_q;
	logic [nba_pkg::IDX_BITS-1:0] best_i_q;
	logic signed [DB-1:0] dx, dy, dz;
	logic [DB-1:0] ax, ay, az;
	logic [MB-1:0] rem_sh, trial;

	always_comb begin
		dx = DB'($signed(rd_q[3*CB-1:2*CB])) - DB'(vx_q);
		dy = DB'($signed(rd_q[2*CB-1:CB])) - DB'(vy_q);
		dz = DB'($signed(rd_q[CB-1:0])) - DB'(vz_q);
		ax = dx[DB-1] ? DB'(-dx) : DB'(dx);
		ay = dy[DB-1] ? DB'(-dy) : DB'(dy);
		az = dz[DB-1] ? DB'(-dz) : DB'(dz);
		rem_sh = {rem_q[MB-3:0], val_q[SB-1:SB-2]};
		trial = {root_q, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_q[bone_slot] <= {coord_x, coord_y, coord_z};
		end
		if (cmd.rd) begin
			rd_q <= mem_q[cmd.addr];
		end
		if (cmd.capture) begin
			vx_q <= coord_x;
			vy_q <= coord_y;
			vz_q <= coord_z;
			last_q <= last_vertex;
		end
		if (cmd.sq) begin
			sqx_q <= QB'(ax * ax);
			sqy_q <= QB'(ay * ay);
			sqz_q <= QB'(az * az);
		end
		if (cmd.sum) begin
			val_q <= SB'(sqx_q) + SB'(sqy_q) + SB'(sqz_q);
			rem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			val_q <= {val_q[SB-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[RB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[RB-2:0], 1'b0};
			end
		end
		if (cmd.cmp && (cmd.first || root_q < best_d_q)) begin
			best_d_q <= root_q;
			best_i_q <= cmd.addr;
		end
		if (cmd.out_load) begin
			bone_index <= cmd.found ? best_i_q : '0;
			assigned <= cmd.found;
			last_out <= last_q;
		end
	end
endmodule

// ----- rtl/nba_ctrl.sv -----
// Controller state machine: handshakes, bone walk counter and sequencing.
// Depends on nba_pkg; drives nba_dp through nba_pkg::dp_cmd_t.
module nba_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nba_pkg::CNT_BITS-1:0]    cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic                            already_attached,
	output logic                            out_valid,
	input  logic                            out_ready,
	output nba_pkg::dp_cmd_t                cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_SQRT = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q, state_d;
	logic [nba_pkg::CNT_BITS-1:0] count_q, k_q, n;
	logic [nba_pkg::STEP_BITS-1:0] step_q;
	logic found_q, in_acc, out_free;

	assign n = count_q > nba_pkg::CNT_BITS'(nba_pkg::MAX_BONES)
		? nba_pkg::CNT_BITS'(nba_pkg::MAX_BONES) : count_q;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.addr = k_q[nba_pkg::IDX_BITS-1:0];
		cmd.first = (k_q == '0);
		cmd.found = found_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (command == nba_pkg::CMD_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d = (already_attached || n == '0) ? S_DONE : S_RD;
					end
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.sq = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (step_q == nba_pkg::STEP_BITS'(nba_pkg::ROOT_BITS - 1)) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = (k_q + 1'b1 == n) ? S_DONE : S_RD;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q <= '0;
			step_q <= '0;
			found_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (cmd.capture) begin
				k_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.cmp) begin
				k_q <= k_q + 1'b1;
				found_q <= 1'b1;
			end
			if (cmd.sum) begin
				step_q <= '0;
			end else if (cmd.sqrt_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result word dropped while stalled.");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp |-> k_q < n)
		else $error("Bone walk ran past the count in use.");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free && state_q == S_DONE)
		else $error("Result register overwritten.");
endmodule
